FILE: hdl/rhr_pkg.sv
// shared constants, tables and helpers for the rgb hue rotation block
`default_nettype none

package rhr_pkg;

    // pixel channel and angle register widths
    localparam int PIX_W   = 8;
    localparam int ANGLE_W = 9;

    // nine matrix coefficients, row-major
    localparam int NCOEF = 9;

    // q30 fixed point sine/cosine
    localparam int Q_FRAC = 30;
    localparam logic [24:0] RAD_PER_DEG_Q30 = 25'd18740330;
    localparam int TAYLOR_TERMS = 7;

    // coefficient numerator width and shared divider dividend width
    localparam int NUM_W = 43;
    localparam int DIV_W = 42;

    // division by a small constant d as a multiply by ceil(2^RCP_SH / d),
    // exact for any dividend below 2^DIV_W while d is at most 1024
    localparam int RCP_SH = DIV_W + 10;
    localparam int RCP_W  = 50;
    localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SH;
    localparam logic [RCP_W-1:0] RCP_6    = RCP_W'((RCP_ONE + 64'd5) / 64'd6);
    localparam logic [RCP_W-1:0] RCP_20   = RCP_W'((RCP_ONE + 64'd19) / 64'd20);
    localparam logic [RCP_W-1:0] RCP_42   = RCP_W'((RCP_ONE + 64'd41) / 64'd42);
    localparam logic [RCP_W-1:0] RCP_72   = RCP_W'((RCP_ONE + 64'd71) / 64'd72);
    localparam logic [RCP_W-1:0] RCP_110  = RCP_W'((RCP_ONE + 64'd109) / 64'd110);
    localparam logic [RCP_W-1:0] RCP_156  = RCP_W'((RCP_ONE + 64'd155) / 64'd156);
    localparam logic [RCP_W-1:0] RCP_210  = RCP_W'((RCP_ONE + 64'd209) / 64'd210);
    localparam logic [RCP_W-1:0] COEF_RECIP = RCP_W'((RCP_ONE + 64'd999) / 64'd1000);

    // luminance weights in thousandths: base, cosine weight, sine weight
    localparam logic signed [10:0] COEF_TERMS [NCOEF][3] = '{
        '{11'sd213,  11'sd787,  -11'sd213},
        '{11'sd715,  -11'sd715, -11'sd715},
        '{11'sd72,   -11'sd72,  11'sd928},
        '{11'sd213,  -11'sd213, 11'sd143},
        '{11'sd715,  11'sd285,  11'sd140},
        '{11'sd72,   -11'sd72,  -11'sd283},
        '{11'sd213,  -11'sd213, -11'sd787},
        '{11'sd715,  -11'sd715, 11'sd715},
        '{11'sd72,   11'sd928,  11'sd72}
    };

    // reciprocal of the factorial ratio (2k)(2k+1) for taylor term k
    function automatic logic [RCP_W-1:0] taylor_recip(input logic [2:0] k);
        logic [RCP_W-1:0] m;
        begin
            case (k)
                3'd1:    m = RCP_6;
                3'd2:    m = RCP_20;
                3'd3:    m = RCP_42;
                3'd4:    m = RCP_72;
                3'd5:    m = RCP_110;
                3'd6:    m = RCP_156;
                3'd7:    m = RCP_210;
                default: m = RCP_6;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rhr_in_if.sv
// input pixel channel: valid/ready handshake with rgb payload
`default_nettype none

interface rhr_in_if;
    import rhr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/rhr_out_if.sv
// output pixel channel: valid/ready handshake with rgb payload
`default_nettype none

interface rhr_out_if;
    import rhr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/rhr_div.sv
// divider by a small constant: reciprocal multiply, one 16-bit digit per cycle
`default_nettype none

module rhr_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rhr_pkg::DIV_W-1:0] dividend,
    input  wire logic [rhr_pkg::RCP_W-1:0] recip,
    output logic                           done,
    output logic [rhr_pkg::DIV_W-1:0]      quotient
);
    import rhr_pkg::*;

    localparam int DIG_W  = 16;
    localparam int NDIG   = 4;
    localparam int MUL_W  = DIG_W * NDIG;
    localparam int PART_W = DIV_W + DIG_W;
    localparam int PRD_W  = DIV_W + RCP_W;
    localparam int CNT_W  = $clog2(NDIG);

    logic [DIV_W-1:0]  num_reg;
    logic [MUL_W-1:0]  rcp_reg;
    logic [PRD_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [PART_W-1:0] part_w;
    logic [PRD_W-1:0]  acc_next;

    // one partial product per cycle, top reciprocal digit first
    always_comb
    begin
        part_w   = PART_W'(num_reg) * PART_W'(rcp_reg[MUL_W-1 -: DIG_W]);
        acc_next = (acc_reg << DIG_W) + PRD_W'(part_w);
    end

    // control: step through the NDIG reciprocal digits, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NDIG - 1);
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: accumulate dividend times reciprocal
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rcp_reg <= MUL_W'(recip);
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            rcp_reg <= rcp_reg << DIG_W;
            acc_reg <= acc_next;
        end
    end

    assign done     = done_reg;
    assign quotient = DIV_W'(acc_reg >> RCP_SH);

endmodule

`default_nettype wire

FILE: hdl/rhr_coef_gen.sv
// coefficient builder: taylor sine/cosine and rounded matrix coefficients
`default_nettype none

module rhr_coef_gen #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [rhr_pkg::ANGLE_W-1:0] wr_angle,
    output logic                             busy,
    output logic signed [COEF_FRAC_BITS+2:0] coef [rhr_pkg::NCOEF]
);
    import rhr_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 3;
    localparam int SH = Q_FRAC - COEF_FRAC_BITS;
    localparam logic [NUM_W-1:0] HALF = NUM_W'(500) << SH;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_X     = 4'd1;
    localparam logic [3:0] ST_X2    = 4'd2;
    localparam logic [3:0] ST_TMUL  = 4'd3;
    localparam logic [3:0] ST_TDIV  = 4'd4;
    localparam logic [3:0] ST_CLAMP = 4'd5;
    localparam logic [3:0] ST_SEL   = 4'd6;
    localparam logic [3:0] ST_CMULC = 4'd7;
    localparam logic [3:0] ST_CMULS = 4'd8;
    localparam logic [3:0] ST_CSUM  = 4'd9;
    localparam logic [3:0] ST_CRND  = 4'd10;
    localparam logic [3:0] ST_CDIV  = 4'd11;

    logic [3:0]              state_reg;
    logic [ANGLE_W-1:0]      angle_reg;
    logic                    which_reg;
    logic [2:0]              k_reg;
    logic [3:0]              idx_reg;
    logic [30:0]             x_reg;
    logic [31:0]             x2_reg;
    logic [31:0]             term_reg;
    logic signed [33:0]      sum_reg;
    logic [30:0]             sr_reg;
    logic [30:0]             cr_reg;
    logic signed [31:0]      s_reg;
    logic signed [31:0]      c_reg;
    logic signed [NUM_W-1:0] pc_reg;
    logic signed [NUM_W-1:0] ps_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic                    neg_reg;
    logic signed [CW-1:0]    coef_reg [NCOEF];

    logic [ANGLE_W-1:0]      a_w;
    logic [1:0]              quad_w;
    logic [6:0]              res_w;
    logic [6:0]              deg_w;
    logic [31:0]             xmul_w;
    logic [61:0]             xsq_w;
    logic [63:0]             tprod_w;
    logic signed [33:0]      tsum_w;
    logic [30:0]             clamp_w;
    logic signed [31:0]      sr_s;
    logic signed [31:0]      cr_s;
    logic [NUM_W-1:0]        mag_w;
    logic [NUM_W-1:0]        rnd_w;
    logic [CW-1:0]           cq_w;

    logic                    div_start;
    logic [DIV_W-1:0]        div_dividend;
    logic [RCP_W-1:0]        div_recip;
    logic                    div_done;
    logic [DIV_W-1:0]        div_q;

    // angle modulo 360, quadrant and residue
    always_comb
    begin
        a_w = (angle_reg >= 9'd360) ? angle_reg - 9'd360 : angle_reg;
        if (a_w >= 9'd270)
        begin
            quad_w = 2'd3;
            res_w  = 7'(a_w - 9'd270);
        end
        else if (a_w >= 9'd180)
        begin
            quad_w = 2'd2;
            res_w  = 7'(a_w - 9'd180);
        end
        else if (a_w >= 9'd90)
        begin
            quad_w = 2'd1;
            res_w  = 7'(a_w - 9'd90);
        end
        else
        begin
            quad_w = 2'd0;
            res_w  = 7'(a_w);
        end
        deg_w = which_reg ? 7'd90 - res_w : res_w;
    end

    // taylor datapath
    always_comb
    begin
        xmul_w  = 32'(deg_w) * 32'(RAD_PER_DEG_Q30);
        xsq_w   = 62'(x_reg) * 62'(x_reg);
        tprod_w = 64'(term_reg) * 64'(x2_reg);
        if (k_reg[0])
            tsum_w = sum_reg - $signed({2'b00, div_q[31:0]});
        else
            tsum_w = sum_reg + $signed({2'b00, div_q[31:0]});
        if (sum_reg[33])
            clamp_w = '0;
        else if (sum_reg > ONE_Q30)
            clamp_w = 31'h4000_0000;
        else
            clamp_w = sum_reg[30:0];
        sr_s = $signed({1'b0, sr_reg});
        cr_s = $signed({1'b0, cr_reg});
    end

    // coefficient rounding: half away from zero on the magnitude
    always_comb
    begin
        mag_w = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        rnd_w = mag_w + HALF;
        cq_w  = div_q[CW-1:0];
    end

    // shared divider requests
    always_comb
    begin
        div_start    = (state_reg == ST_TMUL) || (state_reg == ST_CRND);
        div_dividend = '0;
        div_recip    = COEF_RECIP;
        if (state_reg == ST_TMUL)
        begin
            div_dividend = DIV_W'(tprod_w[63:Q_FRAC]);
            div_recip    = taylor_recip(k_reg);
        end
        else
        begin
            div_dividend = DIV_W'(rnd_w >> SH);
        end
    end

    rhr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .recip    (div_recip),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer and coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            angle_reg <= '0;
            which_reg <= 1'b0;
            k_reg     <= 3'd1;
            idx_reg   <= '0;
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= (i == 0 || i == 4 || i == 8) ? CW'(1) << COEF_FRAC_BITS : '0;
            end
        end
        else if (wr_en)
        begin
            angle_reg <= wr_angle;
            which_reg <= 1'b0;
            state_reg <= ST_X;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_X:
                begin
                    state_reg <= ST_X2;
                end
                ST_X2:
                begin
                    k_reg     <= 3'd1;
                    state_reg <= ST_TMUL;
                end
                ST_TMUL:
                begin
                    state_reg <= ST_TDIV;
                end
                ST_TDIV:
                begin
                    if (div_done)
                    begin
                        if (k_reg == 3'(TAYLOR_TERMS))
                            state_reg <= ST_CLAMP;
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_TMUL;
                        end
                    end
                end
                ST_CLAMP:
                begin
                    if (which_reg)
                        state_reg <= ST_SEL;
                    else
                    begin
                        which_reg <= 1'b1;
                        state_reg <= ST_X;
                    end
                end
                ST_SEL:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_CMULC;
                end
                ST_CMULC:
                begin
                    state_reg <= ST_CMULS;
                end
                ST_CMULS:
                begin
                    state_reg <= ST_CSUM;
                end
                ST_CSUM:
                begin
                    state_reg <= ST_CRND;
                end
                ST_CRND:
                begin
                    state_reg <= ST_CDIV;
                end
                ST_CDIV:
                begin
                    if (div_done)
                    begin
                        coef_reg[idx_reg] <= neg_reg ? CW'(-cq_w) : cq_w;
                        if (idx_reg == 4'(NCOEF - 1))
                            state_reg <= ST_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_CMULC;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_X:
            begin
                x_reg    <= xmul_w[30:0];
                term_reg <= 32'(xmul_w[30:0]);
                sum_reg  <= $signed({3'b000, xmul_w[30:0]});
            end
            ST_X2:
            begin
                x2_reg <= xsq_w[61:Q_FRAC];
            end
            ST_TDIV:
            begin
                if (div_done)
                begin
                    term_reg <= div_q[31:0];
                    sum_reg  <= tsum_w;
                end
            end
            ST_CLAMP:
            begin
                if (which_reg)
                    cr_reg <= clamp_w;
                else
                    sr_reg <= clamp_w;
            end
            ST_SEL:
            begin
                case (quad_w)
                    2'd0:
                    begin
                        s_reg <= sr_s;
                        c_reg <= cr_s;
                    end
                    2'd1:
                    begin
                        s_reg <= cr_s;
                        c_reg <= -sr_s;
                    end
                    2'd2:
                    begin
                        s_reg <= -sr_s;
                        c_reg <= -cr_s;
                    end
                    default:
                    begin
                        s_reg <= -cr_s;
                        c_reg <= sr_s;
                    end
                endcase
            end
            ST_CMULC:
            begin
                pc_reg <= NUM_W'(COEF_TERMS[idx_reg][1]) * NUM_W'(c_reg);
            end
            ST_CMULS:
            begin
                ps_reg <= NUM_W'(COEF_TERMS[idx_reg][2]) * NUM_W'(s_reg);
            end
            ST_CSUM:
            begin
                num_reg <= (NUM_W'(COEF_TERMS[idx_reg][0]) <<< Q_FRAC) + pc_reg + ps_reg;
            end
            ST_CRND:
            begin
                neg_reg <= num_reg[NUM_W-1];
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < NCOEF; i++)
        begin
            coef[i] = coef_reg[i];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rhr_pipe.sv
// three-stage pixel pipeline: products, row sums, clamp to 8 bits
`default_nettype none

module rhr_pipe #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             hold,
    input  wire logic [rhr_pkg::PIX_W-1:0]        in_red,
    input  wire logic [rhr_pkg::PIX_W-1:0]        in_green,
    input  wire logic [rhr_pkg::PIX_W-1:0]        in_blue,
    input  wire logic signed [COEF_FRAC_BITS+2:0] coef [rhr_pkg::NCOEF],
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [rhr_pkg::PIX_W-1:0]             out_red,
    output logic [rhr_pkg::PIX_W-1:0]             out_green,
    output logic [rhr_pkg::PIX_W-1:0]             out_blue
);
    import rhr_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 3;
    localparam int PW = CW + PIX_W + 1;
    localparam int SW = PW + 2;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic signed [PW-1:0] prod_reg [NCOEF];
    logic signed [SW-1:0] sum_reg [3];
    logic [PIX_W-1:0]     pix_reg [3];

    logic                 en1;
    logic                 en2;
    logic                 en3;
    logic                 accept;
    logic [PIX_W-1:0]     chan_w [3];

    // stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en3      = !v3_reg || out_ready;
        en2      = !v2_reg || en3;
        en1      = !v1_reg || en2;
        in_ready = en1 && !hold;
        accept   = in_valid && in_ready;
        chan_w[0] = in_red;
        chan_w[1] = in_green;
        chan_w[2] = in_blue;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= accept;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1: nine coefficient by channel products
    always_ff @(posedge clk)
    begin
        if (en1 && accept)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                prod_reg[i] <= PW'(coef[i]) * PW'($signed({1'b0, chan_w[i % 3]}));
            end
        end
    end

    // stage 2: row sums
    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= SW'(prod_reg[3 * r]) + SW'(prod_reg[3 * r + 1])
                            + SW'(prod_reg[3 * r + 2]);
            end
        end
    end

    // stage 3: drop fraction and saturate to 0..255
    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (sum_reg[r][SW-1])
                    pix_reg[r] <= '0;
                else if (|sum_reg[r][SW-2:COEF_FRAC_BITS+PIX_W])
                    pix_reg[r] <= '1;
                else
                    pix_reg[r] <= sum_reg[r][COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_red   = pix_reg[0];
    assign out_green = pix_reg[1];
    assign out_blue  = pix_reg[2];

endmodule

`default_nettype wire

FILE: hdl/rgb_hue_rotation.sv
// rgb hue rotation: 3x3 luminance-weighted color matrix on a pixel stream
// usage:
//   pix_in carries one rgb pixel per item, pix_out one rotated pixel per item,
//   both with valid/ready; an item moves when valid and ready are both high.
//   cfg_wr_en/cfg_wr_data write the hue angle in degrees (0..511, taken mod 360).
// throughput: one pixel per clock unless pix_out stalls or an angle write runs;
//   the product, row sum and clamp stages each hold one pixel and advance independently.
// path: a pixel passes the product, row sum and clamp registers in turn.
// angle write: the coefficient builder runs sine and cosine, each over 7 taylor
//   terms on the shared reciprocal-multiply divider, then 9 rounded coefficients
//   through the same divider; pix_in.ready is low while it runs.
// reset: the matrix is the identity (angle zero), the pipeline is empty.
// stall: when pix_out.ready is low the output holds; earlier stages keep
//   accepting until every stage is full, then pix_in.ready drops.
`default_nettype none

module rgb_hue_rotation #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [rhr_pkg::ANGLE_W-1:0] cfg_wr_data,
    rhr_in_if.sink                           pix_in,
    rhr_out_if.source                        pix_out
);
    import rhr_pkg::*;

    logic                            busy;
    logic signed [COEF_FRAC_BITS+2:0] coef [NCOEF];

    // coefficient builder
    rhr_coef_gen #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_angle (cfg_wr_data),
        .busy     (busy),
        .coef     (coef)
    );

    // pixel pipeline
    rhr_pipe #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .hold      (busy),
        .in_red    (pix_in.in_red),
        .in_green  (pix_in.in_green),
        .in_blue   (pix_in.in_blue),
        .coef      (coef),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_red   (pix_out.out_red),
        .out_green (pix_out.out_green),
        .out_blue  (pix_out.out_blue)
    );

endmodule

`default_nettype wire
